/* rtl/dps_pkg.sv */
// Shared constants for the dynamic priority scheduler.
// Field widths of the command and result ports, parameter defaults and command codes.
`timescale 1ns / 1ps

package dps_pkg;

  // Fixed port field widths
  localparam int IdW       = 8;
  localparam int PriInW    = 16;
  localparam int TimeInW   = 16;
  localparam int CountOutW = 5;

  // Parameter defaults
  localparam int DefMaxTasks     = 16;
  localparam int DefPriorityBits = 16;
  localparam int DefTimeBits     = 16;

  // Command codes carried on mode
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

endpackage

/* rtl/dynamic_priority_scheduler_unit.sv */
// Dynamic priority scheduler: ordered task list in a circular buffer memory,
// insertion walked one slot at a time by a small sequencer. Depends on dps_pkg.
`timescale 1ns / 1ps

// Channel   Ports                                        Transfer
// --------  -------------------------------------------  -------------------------
// command   mode_i task_id_i task_priority_i task_time_i  start high, busy low
// result    accepted_o running_* finished_* queued_count  done_o high for one cycle
//
// An add moves one entry back per insertion step until it finds its slot or reaches the head;
// a reinserting tick first fetches the running task and removes it from the head, then inserts it the same way.
// A retiring tick ends after the fetch, and a rejected command goes straight to the head read.
// The walk is paced by the single read port of the task memory: each insertion
// step reads one entry, compares priority and writes it one slot further on.
// Reset empties the list at once (count and head pointer); no clearing pass.
// The receiver cannot stall: each result is shown on done_o for one cycle.
module dynamic_priority_scheduler_unit
  import dps_pkg::*;
#(
  parameter int MAX_TASKS     = DefMaxTasks,
  parameter int PRIORITY_BITS = DefPriorityBits,
  parameter int TIME_BITS     = DefTimeBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode_i,
  input  logic [IdW-1:0]              task_id_i,
  input  logic signed [PriInW-1:0]    task_priority_i,
  input  logic [TimeInW-1:0]          task_time_i,
  output logic                        done_o,
  output logic                        accepted_o,
  output logic                        running_valid_o,
  output logic [IdW-1:0]              running_id_o,
  output logic signed [PriInW-1:0]    running_priority_o,
  output logic [TimeInW-1:0]          running_time_o,
  output logic                        finished_valid_o,
  output logic [IdW-1:0]              finished_id_o,
  output logic [CountOutW-1:0]        queued_count_o
);

  // Sizes derived from parameters
  localparam int AW    = (MAX_TASKS > 2) ? $clog2(MAX_TASKS) : 1;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = $clog2(MAX_TASKS + 1);
  localparam int WW    = 34;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TASKS);
  localparam logic signed [WW-1:0] PMAX_W =
    WW'((64'sd1 <<< (PRIORITY_BITS - 1)) - 64'sd1);
  localparam logic signed [WW-1:0] PMIN_W = ~PMAX_W;
  localparam logic [WW-1:0] TMAX_W = WW'((64'd1 << TIME_BITS) - 64'd1);
  localparam logic [PRIORITY_BITS-1:0] PRI_MIN_P = {1'b1, {(PRIORITY_BITS-1){1'b0}}};
  localparam logic [TIME_BITS-1:0] TIME_ONE = TIME_BITS'(1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TRD  = 3'd1;
  localparam logic [2:0] S_TCK  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_INSW = 3'd4;
  localparam logic [2:0] S_HEAD = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  typedef struct packed {
    logic [IdW-1:0]           id;
    logic [PRIORITY_BITS-1:0] pri;
    logic [TIME_BITS-1:0]     tm;
  } entry_t;

  // Task memory, circular buffer
  entry_t mem_q [DEPTH];
  entry_t rd_q;
  logic   we;
  logic   re;
  logic [AW-1:0] wa;
  logic [AW-1:0] ra;
  entry_t wd;

  logic [2:0]               state_q, state_d;
  logic [AW-1:0]            head_q, head_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            k_q, k_d;
  entry_t                   new_q, new_d;
  logic                     acc_q, acc_d;
  logic                     fin_q, fin_d;
  logic [IdW-1:0]           fin_id_q, fin_id_d;

  // Input saturation into the stored widths
  logic signed [WW-1:0] pri_ext;
  logic signed [WW-1:0] pri_sat;
  logic [WW-1:0]        tm_ext;
  logic [WW-1:0]        tm_sat;
  entry_t               in_entry;

  assign pri_ext = WW'(task_priority_i);
  assign tm_ext  = WW'(task_time_i);

  always_comb begin
    priority if (pri_ext > PMAX_W) begin
      pri_sat = PMAX_W;
    end else if (pri_ext < PMIN_W) begin
      pri_sat = PMIN_W;
    end else begin
      pri_sat = pri_ext;
    end
    tm_sat      = (tm_ext > TMAX_W) ? TMAX_W : tm_ext;
    in_entry.id  = task_id_i;
    in_entry.pri = pri_sat[PRIORITY_BITS-1:0];
    in_entry.tm  = tm_sat[TIME_BITS-1:0];
  end

  // Slot addresses relative to the head
  logic [AW-1:0] k_addr;
  logic [AW-1:0] km1_addr;
  logic [CW-1:0] k_m1;

  assign k_m1     = k_q - CW'(1);
  assign k_addr   = head_q + k_q[AW-1:0];
  assign km1_addr = head_q + k_m1[AW-1:0];

  // Sequencer
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    k_d      = k_q;
    new_d    = new_q;
    acc_d    = acc_q;
    fin_d    = fin_q;
    fin_id_d = fin_id_q;
    we       = 1'b0;
    re       = 1'b0;
    wa       = k_addr;
    ra       = head_q;
    wd       = new_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          new_d    = in_entry;
          acc_d    = 1'b0;
          fin_d    = 1'b0;
          fin_id_d = '0;
          if (mode_i == MODE_ADD) begin
            if (count_q < MAX_CNT && task_time_i != '0) begin
              acc_d   = 1'b1;
              k_d     = count_q;
              state_d = S_INS;
            end else begin
              state_d = S_HEAD;
            end
          end else begin
            if (count_q != '0) begin
              acc_d   = 1'b1;
              state_d = S_TRD;
            end else begin
              state_d = S_HEAD;
            end
          end
        end
      end

      // fetch the running task
      S_TRD: begin
        re      = 1'b1;
        ra      = head_q;
        state_d = S_TCK;
      end

      // retire it, or lower it and reinsert
      S_TCK: begin
        head_d  = head_q + AW'(1);
        count_d = count_q - CW'(1);
        if (rd_q.tm <= TIME_ONE) begin
          fin_d    = 1'b1;
          fin_id_d = rd_q.id;
          state_d  = S_HEAD;
        end else begin
          new_d.id  = rd_q.id;
          new_d.pri = (rd_q.pri != PRI_MIN_P) ? rd_q.pri - PRIORITY_BITS'(1) : rd_q.pri;
          new_d.tm  = rd_q.tm - TIME_ONE;
          k_d       = count_q - CW'(1);
          state_d   = S_INS;
        end
      end

      // walk from the tail: place at front, or read the entry before slot k
      S_INS: begin
        if (k_q == '0) begin
          we      = 1'b1;
          wa      = head_q;
          wd      = new_q;
          count_d = count_q + CW'(1);
          state_d = S_HEAD;
        end else begin
          re      = 1'b1;
          ra      = km1_addr;
          state_d = S_INSW;
        end
      end

      // stop behind an entry of equal or higher priority, else move it back
      S_INSW: begin
        we = 1'b1;
        wa = k_addr;
        if ($signed(rd_q.pri) >= $signed(new_q.pri)) begin
          wd      = new_q;
          count_d = count_q + CW'(1);
          state_d = S_HEAD;
        end else begin
          wd      = rd_q;
          k_d     = k_m1;
          state_d = S_INS;
        end
      end

      S_HEAD: begin
        re      = 1'b1;
        ra      = head_q;
        state_d = S_OUT;
      end

      S_OUT: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      k_q     <= '0;
      acc_q   <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      k_q     <= k_d;
      acc_q   <= acc_d;
      fin_q   <= fin_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    new_q    <= new_d;
    fin_id_q <= fin_id_d;
  end

  // Memory write port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_q <= mem_q[ra];
    end
  end

  // Result fields, sized to the port widths
  logic signed [WW-1:0] head_pri_w;
  logic [WW-1:0]        head_tm_w;
  logic [WW-1:0]        count_w;
  logic                 any_task;

  assign any_task   = count_q != '0;
  assign head_pri_w = WW'($signed(rd_q.pri));
  assign head_tm_w  = WW'(rd_q.tm);
  assign count_w    = WW'(count_q);

  assign busy               = state_q != S_IDLE;
  assign done_o             = state_q == S_OUT;
  assign accepted_o         = acc_q;
  assign running_valid_o    = any_task;
  assign running_id_o       = any_task ? rd_q.id : '0;
  assign running_priority_o = any_task ? head_pri_w[PriInW-1:0] : '0;
  assign running_time_o     = any_task ? head_tm_w[TimeInW-1:0] : '0;
  assign finished_valid_o   = fin_q;
  assign finished_id_o      = fin_q ? fin_id_q : '0;
  assign queued_count_o     = count_w[CountOutW-1:0];

endmodule

/* verif/dps_checker.sv */
// Result checker for the dynamic priority scheduler: keeps its own task list,
// predicts one report per command transfer and compares it with done_o reports. Needs dps_pkg.
`timescale 1ns / 1ps

module dps_checker
  import dps_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     mode_i,
  input  logic [IdW-1:0]           task_id_i,
  input  logic signed [PriInW-1:0] task_priority_i,
  input  logic [TimeInW-1:0]       task_time_i,
  input  logic                     done_o,
  input  logic                     accepted_o,
  input  logic                     running_valid_o,
  input  logic [IdW-1:0]           running_id_o,
  input  logic signed [PriInW-1:0] running_priority_o,
  input  logic [TimeInW-1:0]       running_time_o,
  input  logic                     finished_valid_o,
  input  logic [IdW-1:0]           finished_id_o,
  input  logic [CountOutW-1:0]     queued_count_o,
  output int                       mismatches,
  output int                       reports_pending
);

  typedef struct packed {
    logic                     accepted;
    logic                     run_valid;
    logic [IdW-1:0]           run_id;
    logic signed [PriInW-1:0] run_pri;
    logic [TimeInW-1:0]       run_time;
    logic                     fin_valid;
    logic [IdW-1:0]           fin_id;
    logic [CountOutW-1:0]     count;
  } sched_report_t;

  localparam logic signed [PriInW-1:0] PriFloor = {1'b1, {(PriInW-1){1'b0}}};

  // Predicted task list, highest priority first; only entries below held are valid.
  // Port widths equal the default priority and time widths, so no saturation applies.
  logic [IdW-1:0]           list_id   [DefMaxTasks];
  logic signed [PriInW-1:0] list_pri  [DefMaxTasks];
  logic [TimeInW-1:0]       list_time [DefMaxTasks];
  int                       held = 0;

  sched_report_t            report_q[$];

  // Insert behind every entry whose priority is at least the new one
  function automatic void insert_task(logic [IdW-1:0] id, logic signed [PriInW-1:0] pri,
                                      logic [TimeInW-1:0] ticks);
    int pos;
    pos = 0;
    while (pos < held && list_pri[pos] >= pri) pos++;
    for (int k = held; k > pos; k--) begin
      list_id[k]   = list_id[k-1];
      list_pri[k]  = list_pri[k-1];
      list_time[k] = list_time[k-1];
    end
    list_id[pos]   = id;
    list_pri[pos]  = pri;
    list_time[pos] = ticks;
    held++;
  endfunction

  function automatic void remove_head();
    for (int k = 1; k < held; k++) begin
      list_id[k-1]   = list_id[k];
      list_pri[k-1]  = list_pri[k];
      list_time[k-1] = list_time[k];
    end
    held--;
  endfunction

  // Apply one command to the predicted list and build the report it causes
  function automatic sched_report_t schedule_step(logic mode, logic [IdW-1:0] id,
                                                  logic signed [PriInW-1:0] pri,
                                                  logic [TimeInW-1:0] ticks);
    sched_report_t            r;
    logic [IdW-1:0]           hid;
    logic signed [PriInW-1:0] hpri;
    logic [TimeInW-1:0]       htime;
    r = '0;
    if (mode == MODE_ADD) begin
      if (held < DefMaxTasks && ticks != '0) begin
        insert_task(id, pri, ticks);
        r.accepted = 1'b1;
      end
    end else if (held > 0) begin
      r.accepted = 1'b1;
      if (list_time[0] <= 1) begin
        // head used up its time: retire it
        r.fin_valid = 1'b1;
        r.fin_id    = list_id[0];
        remove_head();
      end else begin
        // one tick used; priority ages by one, stopping at the floor
        hid   = list_id[0];
        hpri  = list_pri[0];
        htime = list_time[0] - 1'b1;
        if (hpri != PriFloor) hpri = hpri - PriInW'(1);
        remove_head();
        insert_task(hid, hpri, htime);
      end
    end
    if (held > 0) begin
      r.run_valid = 1'b1;
      r.run_id    = list_id[0];
      r.run_pri   = list_pri[0];
      r.run_time  = list_time[0];
    end
    r.count = CountOutW'(held);
    return r;
  endfunction

  function automatic string diff_fields(sched_report_t e, sched_report_t a);
    string s;
    s = "";
    if (e.accepted  !== a.accepted)  s = {s, " accepted"};
    if (e.run_valid !== a.run_valid) s = {s, " running_valid"};
    if (e.run_id    !== a.run_id)    s = {s, " running_id"};
    if (e.run_pri   !== a.run_pri)   s = {s, " running_priority"};
    if (e.run_time  !== a.run_time)  s = {s, " running_time"};
    if (e.fin_valid !== a.fin_valid) s = {s, " finished_valid"};
    if (e.fin_id    !== a.fin_id)    s = {s, " finished_id"};
    if (e.count     !== a.count)     s = {s, " queued_count"};
    return s;
  endfunction

  // Compare reports first, then predict for a command transfer on the same edge
  always @(posedge clk_i) begin
    sched_report_t act;
    sched_report_t exp;
    string         diff;
    if (rst_ni) begin
      if (done_o) begin
        act = '{accepted_o, running_valid_o, running_id_o, running_priority_o,
                running_time_o, finished_valid_o, finished_id_o, queued_count_o};
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: report with no command outstanding (id=%02h cnt=%0d)",
                     $realtime, running_id_o, queued_count_o);
        end else begin
          exp  = report_q.pop_front();
          diff = diff_fields(exp, act);
          if (diff != "") begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: report mismatch on%s", $realtime, diff);
              $display("  exp acc=%0b run=%0b id=%02h pri=%0d time=%0d fin=%0b fid=%02h cnt=%0d",
                       exp.accepted, exp.run_valid, exp.run_id, exp.run_pri, exp.run_time,
                       exp.fin_valid, exp.fin_id, exp.count);
              $display("  act acc=%0b run=%0b id=%02h pri=%0d time=%0d fin=%0b fid=%02h cnt=%0d",
                       act.accepted, act.run_valid, act.run_id, act.run_pri, act.run_time,
                       act.fin_valid, act.fin_id, act.count);
            end
          end
        end
      end
      if (start && !busy)
        report_q.push_back(schedule_step(mode_i, task_id_i, task_priority_i, task_time_i));
      reports_pending <= report_q.size();
    end else begin
      // reset empties the predicted list
      mismatches = 0;
      held       = 0;
      report_q.delete();
      reports_pending <= 0;
    end
  end

endmodule

/* verif/tb_dynamic_priority_scheduler_unit.sv */
// Testbench top for dynamic_priority_scheduler_unit: directed and random command
// streams with random gaps; checking is done by dps_checker. Needs dps_pkg.
`timescale 1ns / 1ps

module tb_dynamic_priority_scheduler_unit
  import dps_pkg::*;
;

  localparam int RandomCommands = 1900;
  localparam int IdleLimit      = 2000;
  localparam int SettleCycles   = 40;

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     start           = 1'b0;
  logic                     mode_i          = MODE_ADD;
  logic [IdW-1:0]           task_id_i       = '0;
  logic signed [PriInW-1:0] task_priority_i = '0;
  logic [TimeInW-1:0]       task_time_i     = '0;
  logic                     busy;
  logic                     done_o;
  logic                     accepted_o;
  logic                     running_valid_o;
  logic [IdW-1:0]           running_id_o;
  logic signed [PriInW-1:0] running_priority_o;
  logic [TimeInW-1:0]       running_time_o;
  logic                     finished_valid_o;
  logic [IdW-1:0]           finished_id_o;
  logic [CountOutW-1:0]     queued_count_o;
  int                       mismatches;
  int                       reports_pending;
  int                       idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  dynamic_priority_scheduler_unit dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .task_id_i, .task_priority_i, .task_time_i,
    .done_o, .accepted_o, .running_valid_o, .running_id_o, .running_priority_o,
    .running_time_o, .finished_valid_o, .finished_id_o, .queued_count_o
  );

  dps_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .task_id_i, .task_priority_i, .task_time_i,
    .done_o, .accepted_o, .running_valid_o, .running_id_o, .running_priority_o,
    .running_time_o, .finished_valid_o, .finished_id_o, .queued_count_o,
    .mismatches, .reports_pending
  );

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [PriInW-1:0] PriFloorLit();
    return {1'b1, {(PriInW-1){1'b0}}};
  endfunction

  // Present one command and hold it until the transfer
  task automatic issue(input logic mode, input logic [IdW-1:0] id,
                       input logic signed [PriInW-1:0] pri, input logic [TimeInW-1:0] ticks);
    start           <= 1'b1;
    mode_i          <= mode;
    task_id_i       <= id;
    task_priority_i <= pri;
    task_time_i     <= ticks;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold off until every outstanding report has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (reports_pending != 0);
  endtask

  initial begin
    int                       sent;
    int                       phase_len;
    int                       add_pct;
    bit                       no_gaps;
    int                       r;
    logic                     mode;
    logic signed [PriInW-1:0] pri;
    logic [TimeInW-1:0]       ticks;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty tick, floor priority, zero time, top priority ties, retire
    issue(MODE_TICK, 8'h33, 16'sh1234, 16'h0001);
    issue(MODE_ADD,  8'h00, PriFloorLit(), 16'hFFFF);
    issue(MODE_TICK, 8'h00, '0, '0);
    issue(MODE_ADD,  8'h77, 16'sd5, 16'h0000);
    issue(MODE_ADD,  8'hFF, 16'sh7FFF, 16'h0002);
    issue(MODE_ADD,  8'h5A, 16'sh7FFF, 16'h0001);
    issue(MODE_TICK, 8'hFF, 16'sh7FFF, 16'hFFFF);
    issue(MODE_TICK, 8'h00, '0, '0);
    // fill the list with mixed and equal priorities
    for (int k = 0; k < 14; k++)
      issue(MODE_ADD, 8'h10 + k[7:0], (k % 4 == 2) ? 16'sd100 : ((k % 4 == 1) ? -16'sd1 : 16'sd0),
            TimeInW'(k % 3 + 1));
    // add to a full list, then tick with the list full
    issue(MODE_ADD,  8'hAA, 16'sh7FFF, 16'h0005);
    issue(MODE_TICK, 8'h00, '0, '0);
    drain();

    // Random phases, each either add heavy or tick heavy at random
    sent = 0;
    while (sent < RandomCommands) begin
      phase_len = $urandom_range(80, 20);
      add_pct   = ($urandom_range(1, 0) == 1) ? 70 : 35;
      no_gaps   = ($urandom_range(3, 0) == 0);
      for (int i = 0; i < phase_len; i++) begin
        mode = ($urandom_range(99, 0) < add_pct) ? MODE_ADD : MODE_TICK;
        // priorities: mostly a narrow band for ties, some full range and extremes
        r = $urandom_range(99, 0);
        if (r < 50)      pri = PriInW'($signed($urandom_range(6, 0)) - 3);
        else if (r < 80) pri = PriInW'($urandom);
        else if (r < 90) pri = 16'sh7FFF;
        else             pri = PriFloorLit();
        // times: mostly short so tasks retire; rare long ones sit at the bottom
        r = $urandom_range(299, 0);
        if (r == 0) begin
          ticks = TimeInW'($urandom);
          pri   = PriFloorLit() + PriInW'($urandom_range(768, 0));
        end else if (r < 15) begin
          ticks = '0;
        end else if (r < 200) begin
          ticks = TimeInW'($urandom_range(3, 1));
        end else begin
          ticks = TimeInW'($urandom_range(20, 4));
        end
        issue(mode, IdW'($urandom), pri, ticks);
        sent++;
        if (!no_gaps) begin
          r = $urandom_range(99, 0);
          if (r >= 98)      pause($urandom_range(60, 20));
          else if (r >= 90) pause($urandom_range(12, 4));
          else if (r >= 55) pause($urandom_range(3, 1));
        end
      end
      if ($urandom_range(4, 0) == 0) drain();
    end

    // Wait out the last reports, then allow for a stray one
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dps_pkg.sv
rtl/dynamic_priority_scheduler_unit.sv
verif/dps_checker.sv
verif/tb_dynamic_priority_scheduler_unit.sv
